// ===== rtl/pse_pkg.sv =====
// Package with command codes and fixed field widths of the point store.
package pse_pkg;

   localparam int CMD_W      = 3;
   localparam int FIELD_W    = 16;
   localparam int CNT_OUT_W  = 4;
   localparam int IDX_OUT_W  = 4;
   localparam int DIST_OUT_W = 34;

   localparam logic [CMD_W-1:0] CMD_ADD_TOP = 3'd0;
   localparam logic [CMD_W-1:0] CMD_DEL_TOP = 3'd1;
   localparam logic [CMD_W-1:0] CMD_ADD_BOT = 3'd2;
   localparam logic [CMD_W-1:0] CMD_DEL_BOT = 3'd3;
   localparam logic [CMD_W-1:0] CMD_ROTATE  = 3'd4;
   localparam logic [CMD_W-1:0] CMD_CLEAR   = 3'd5;
   localparam logic [CMD_W-1:0] CMD_PAIR    = 3'd6;
   localparam logic [CMD_W-1:0] CMD_SORT    = 3'd7;

   // Handshake between the sequencer and the squared distance unit.
   typedef struct packed {
      logic start;
   } sqd_ctl_type;

   typedef struct packed {
      logic done;
   } sqd_sts_type;

endpackage

// ===== rtl/pse_if.sv =====
// Channel interfaces for command requests and responses.
interface pse_req_if;
   logic                              valid;
   logic                              ready;
   logic [pse_pkg::CMD_W-1:0]         cmd;
   logic signed [pse_pkg::FIELD_W-1:0] px;
   logic signed [pse_pkg::FIELD_W-1:0] py;
   logic signed [pse_pkg::FIELD_W-1:0] pz;
   modport source (output valid, cmd, px, py, pz, input ready);
   modport sink (input valid, cmd, px, py, pz, output ready);
endinterface

interface pse_rsp_if;
   logic                                  valid;
   logic                                  ready;
   logic [pse_pkg::CNT_OUT_W-1:0]         stored_count;
   logic                                  pair_valid;
   logic [pse_pkg::IDX_OUT_W-1:0]         near_first;
   logic [pse_pkg::IDX_OUT_W-1:0]         near_second;
   logic [pse_pkg::DIST_OUT_W-1:0]        near_dist_sq;
   logic [pse_pkg::IDX_OUT_W-1:0]         far_first;
   logic [pse_pkg::IDX_OUT_W-1:0]         far_second;
   logic [pse_pkg::DIST_OUT_W-1:0]        far_dist_sq;
   logic signed [pse_pkg::FIELD_W-1:0]    out_x;
   logic signed [pse_pkg::FIELD_W-1:0]    out_y;
   logic signed [pse_pkg::FIELD_W-1:0]    out_z;
   logic                                  last;
   modport source (output valid, stored_count, pair_valid, near_first, near_second,
                   near_dist_sq, far_first, far_second, far_dist_sq, out_x, out_y,
                   out_z, last, input ready);
   modport sink (input valid, stored_count, pair_valid, near_first, near_second,
                 near_dist_sq, far_first, far_second, far_dist_sq, out_x, out_y,
                 out_z, last, output ready);
endinterface

// ===== rtl/point_store_pair_extremes_top.sv =====
// Top level of the point store with pair extremes query and sorted readout.
//
// The block holds SLOTS points. A command arrives as one transfer on req_ch
// (cmd, px, py, pz); every command answers on rsp_ch with one transfer, except
// the sorted readout, which sends one transfer per stored point (at least one)
// with last set on the final one. Every response carries the count after the
// command. Only one command is in flight: req_ch.ready is high only while the
// sequencer is idle, so a stalled receiver simply holds the block.
// The time to a response depends on the command. Top and bottom searches walk
// one slot per cycle for add top and both deletes. Add bottom and rotate move
// one point at a time, each read from the point memory and then written back.
// A pair query runs each occupied pair through the shared squared distance unit
// (one multiplier, three axes in turn) and steps past empty slots one per cycle.
// A sorted readout forms a key per stored point, orders the keys with an exchange
// sort and sends one response transfer per point, each held until the receiver
// takes it.
// Synchronous reset empties the store (no marks, count zero, no top); point
// coordinates are not cleared, and only those of occupied slots reach a distance or a response.
module point_store_pair_extremes_top #(
   parameter int SLOTS      = 10,
   parameter int COORD_BITS = 16
) (
   input  logic         clock,
   input  logic         reset,
   pse_req_if.sink      req_ch,
   pse_rsp_if.source    rsp_ch
);
   localparam int CB   = COORD_BITS;
   localparam int PW   = 3 * CB;
   localparam int IW   = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int CW   = $clog2(SLOTS + 1);
   localparam int DW   = 2 * (CB + 1) + 2;
   localparam int SW   = IW + DW;
   localparam int WIDE = (CB > 16) ? CB : 16;
   localparam int OW   = DW + pse_pkg::DIST_OUT_W;
   localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);
   localparam logic [IW-1:0] PREV_IDX = IW'(SLOTS - 2);
   localparam logic [CW-1:0] NSLOTS   = CW'(SLOTS);

   // Sequencer states.
   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_ADD_PRB  = 5'd1;
   localparam logic [4:0] ST_DEL_TOP  = 5'd2;
   localparam logic [4:0] ST_SH_RD    = 5'd3;
   localparam logic [4:0] ST_SH_WR    = 5'd4;
   localparam logic [4:0] ST_PUT0     = 5'd5;
   localparam logic [4:0] ST_DEL_BOT  = 5'd6;
   localparam logic [4:0] ST_ROT_RD0  = 5'd7;
   localparam logic [4:0] ST_ROT_SAVE = 5'd8;
   localparam logic [4:0] ST_ROT_RD   = 5'd9;
   localparam logic [4:0] ST_ROT_WR   = 5'd10;
   localparam logic [4:0] ST_ROT_LAST = 5'd11;
   localparam logic [4:0] ST_PQ_I     = 5'd12;
   localparam logic [4:0] ST_PQ_A     = 5'd13;
   localparam logic [4:0] ST_PQ_J     = 5'd14;
   localparam logic [4:0] ST_PQ_B     = 5'd15;
   localparam logic [4:0] ST_PQ_WAIT  = 5'd16;
   localparam logic [4:0] ST_KEY_SCAN = 5'd17;
   localparam logic [4:0] ST_KEY_A    = 5'd18;
   localparam logic [4:0] ST_KEY_WAIT = 5'd19;
   localparam logic [4:0] ST_SO_I     = 5'd20;
   localparam logic [4:0] ST_SO_CUR   = 5'd21;
   localparam logic [4:0] ST_SO_J     = 5'd22;
   localparam logic [4:0] ST_SO_CMP   = 5'd23;
   localparam logic [4:0] ST_RO_RD    = 5'd24;
   localparam logic [4:0] ST_RO_IDX   = 5'd25;
   localparam logic [4:0] ST_RO_OUT   = 5'd26;
   localparam logic [4:0] ST_RO_WAIT  = 5'd27;
   localparam logic [4:0] ST_RESP     = 5'd28;
   localparam logic [4:0] ST_WAIT     = 5'd29;

   logic [4:0]        state_ff, state_in;
   logic [PW-1:0]     pt_ff, pt_in, a_ff, a_in;
   logic [SLOTS-1:0]  used_ff, used_in;
   logic [CW-1:0]     count_ff, count_in;
   logic [IW-1:0]     top_ff, top_in, ptr_ff, ptr_in;
   logic              top_none_ff, top_none_in;
   logic [CW-1:0]     i_ff, i_in, j_ff, j_in, n_ff, n_in;
   logic              have_ff, have_in;
   logic [IW-1:0]     n1_ff, n1_in, n2_ff, n2_in, f1_ff, f1_in, f2_ff, f2_in;
   logic [DW-1:0]     nd_ff, nd_in, fd_ff, fd_in;
   logic [SW-1:0]     cur_ff, cur_in;
   logic [PW-1:0]     opt_ff, opt_in;
   logic              rsp_valid_ff, rsp_valid_in, last_ff, last_in;

   // Point memory and sort scratch memory, one write and one read port each.
   logic [PW-1:0]     coord_mem_ff [SLOTS];
   logic [SW-1:0]     sort_mem_ff [SLOTS];
   logic [PW-1:0]     cm_rdata_ff, cm_wdata;
   logic [SW-1:0]     sm_rdata_ff, sm_wdata;
   logic [IW-1:0]     cm_raddr, cm_waddr, sm_raddr, sm_waddr;
   logic              cm_we, sm_we;

   pse_pkg::sqd_ctl_type u_ctl;
   pse_pkg::sqd_sts_type u_sts;
   logic [PW-1:0]     u_a, u_b;
   logic [DW-1:0]     u_dist;

   logic [WIDE-1:0]   in_x, in_y, in_z;
   logic              accept;

   pse_sqdist #(.COORD_BITS(CB)) u_sqdist (
      .clock  (clock),
      .reset  (reset),
      .ctl    (u_ctl),
      .a      (u_a),
      .b      (u_b),
      .sts    (u_sts),
      .sum_sq (u_dist)
   );

   // Incoming coordinates keep their low COORD_BITS bits as a signed value.
   assign in_x   = WIDE'($unsigned(req_ch.px));
   assign in_y   = WIDE'($unsigned(req_ch.py));
   assign in_z   = WIDE'($unsigned(req_ch.pz));
   assign accept = req_ch.valid && req_ch.ready;

   always_comb begin
      state_in     = state_ff;
      pt_in        = pt_ff;
      a_in         = a_ff;
      used_in      = used_ff;
      count_in     = count_ff;
      top_in       = top_ff;
      top_none_in  = top_none_ff;
      ptr_in       = ptr_ff;
      i_in         = i_ff;
      j_in         = j_ff;
      n_in         = n_ff;
      have_in      = have_ff;
      n1_in        = n1_ff;
      n2_in        = n2_ff;
      f1_in        = f1_ff;
      f2_in        = f2_ff;
      nd_in        = nd_ff;
      fd_in        = fd_ff;
      cur_in       = cur_ff;
      opt_in       = opt_ff;
      rsp_valid_in = rsp_valid_ff;
      last_in      = last_ff;
      cm_we        = 1'b0;
      cm_waddr     = ptr_ff;
      cm_wdata     = pt_ff;
      cm_raddr     = ptr_ff;
      sm_we        = 1'b0;
      sm_waddr     = i_ff[IW-1:0];
      sm_wdata     = cur_ff;
      sm_raddr     = i_ff[IW-1:0];
      u_ctl.start  = 1'b0;
      u_a          = a_ff;
      u_b          = cm_rdata_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pt_in   = {in_x[CB-1:0], in_y[CB-1:0], in_z[CB-1:0]};
               have_in = 1'b0;
               n1_in   = '0;
               n2_in   = '0;
               f1_in   = '0;
               f2_in   = '0;
               nd_in   = '0;
               fd_in   = '0;
               opt_in  = '0;
               state_in = ST_RESP;
               unique case (req_ch.cmd)
                  pse_pkg::CMD_ADD_TOP: begin
                     if (count_ff != NSLOTS) begin
                        ptr_in = (top_none_ff || top_ff == LAST_IDX) ? '0 : top_ff + 1'b1;
                        state_in = ST_ADD_PRB;
                     end
                  end
                  pse_pkg::CMD_DEL_TOP: begin
                     if (count_ff != '0) begin
                        ptr_in   = top_ff;
                        state_in = ST_DEL_TOP;
                     end
                  end
                  pse_pkg::CMD_ADD_BOT: begin
                     count_in    = count_ff - CW'(used_ff[SLOTS-1]) + 1'b1;
                     used_in     = {used_ff[SLOTS-2:0], 1'b1};
                     top_in      = (top_none_ff || top_ff == LAST_IDX) ? '0 : top_ff + 1'b1;
                     top_none_in = 1'b0;
                     ptr_in      = PREV_IDX;
                     state_in    = ST_SH_RD;
                  end
                  pse_pkg::CMD_DEL_BOT: begin
                     if (count_ff != '0) begin
                        ptr_in   = '0;
                        state_in = ST_DEL_BOT;
                     end
                  end
                  pse_pkg::CMD_ROTATE: begin
                     if (count_ff != '0) begin
                        used_in  = {used_ff[0], used_ff[SLOTS-1:1]};
                        top_in   = (top_ff == '0) ? LAST_IDX : top_ff - 1'b1;
                        state_in = ST_ROT_RD0;
                     end
                  end
                  pse_pkg::CMD_CLEAR: begin
                     used_in     = '0;
                     count_in    = '0;
                     top_none_in = 1'b1;
                  end
                  pse_pkg::CMD_PAIR: begin
                     if (count_ff > CW'(1)) begin
                        i_in     = '0;
                        state_in = ST_PQ_I;
                     end
                  end
                  default: begin
                     n_in     = '0;
                     j_in     = '0;
                     state_in = ST_KEY_SCAN;
                  end
               endcase
            end
         end
         ST_ADD_PRB: begin
            if (used_ff[ptr_ff]) begin
               ptr_in = (ptr_ff == LAST_IDX) ? '0 : ptr_ff + 1'b1;
            end else begin
               cm_we           = 1'b1;
               used_in[ptr_ff] = 1'b1;
               top_in          = ptr_ff;
               top_none_in     = 1'b0;
               count_in        = count_ff + 1'b1;
               state_in        = ST_RESP;
            end
         end
         ST_DEL_TOP: begin
            if (used_ff[ptr_ff]) begin
               used_in[ptr_ff] = 1'b0;
               count_in        = count_ff - 1'b1;
               top_in          = (ptr_ff == '0) ? LAST_IDX : ptr_ff - 1'b1;
               state_in        = ST_RESP;
            end else begin
               ptr_in = (ptr_ff == '0) ? LAST_IDX : ptr_ff - 1'b1;
            end
         end
         ST_SH_RD: begin
            state_in = ST_SH_WR;
         end
         ST_SH_WR: begin
            cm_we    = 1'b1;
            cm_waddr = ptr_ff + 1'b1;
            cm_wdata = cm_rdata_ff;
            if (ptr_ff == '0) begin
               state_in = ST_PUT0;
            end else begin
               ptr_in   = ptr_ff - 1'b1;
               state_in = ST_SH_RD;
            end
         end
         ST_PUT0: begin
            cm_we    = 1'b1;
            cm_waddr = '0;
            state_in = ST_RESP;
         end
         ST_DEL_BOT: begin
            if (used_ff[ptr_ff]) begin
               used_in[ptr_ff] = 1'b0;
               count_in        = count_ff - 1'b1;
               state_in        = ST_RESP;
            end else begin
               ptr_in = ptr_ff + 1'b1;
            end
         end
         ST_ROT_RD0: begin
            cm_raddr = '0;
            state_in = ST_ROT_SAVE;
         end
         ST_ROT_SAVE: begin
            a_in     = cm_rdata_ff;
            ptr_in   = '0;
            state_in = ST_ROT_RD;
         end
         ST_ROT_RD: begin
            cm_raddr = ptr_ff + 1'b1;
            state_in = ST_ROT_WR;
         end
         ST_ROT_WR: begin
            cm_we    = 1'b1;
            cm_wdata = cm_rdata_ff;
            if (ptr_ff == PREV_IDX) begin
               state_in = ST_ROT_LAST;
            end else begin
               ptr_in   = ptr_ff + 1'b1;
               state_in = ST_ROT_RD;
            end
         end
         ST_ROT_LAST: begin
            cm_we    = 1'b1;
            cm_waddr = LAST_IDX;
            cm_wdata = a_ff;
            state_in = ST_RESP;
         end
         ST_PQ_I: begin
            cm_raddr = i_ff[IW-1:0];
            if (i_ff >= CW'(SLOTS - 1)) begin
               state_in = ST_RESP;
            end else if (!used_ff[i_ff[IW-1:0]]) begin
               i_in = i_ff + 1'b1;
            end else begin
               state_in = ST_PQ_A;
            end
         end
         ST_PQ_A: begin
            a_in     = cm_rdata_ff;
            j_in     = i_ff + 1'b1;
            state_in = ST_PQ_J;
         end
         ST_PQ_J: begin
            cm_raddr = j_ff[IW-1:0];
            if (j_ff == NSLOTS) begin
               i_in     = i_ff + 1'b1;
               state_in = ST_PQ_I;
            end else if (!used_ff[j_ff[IW-1:0]]) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = ST_PQ_B;
            end
         end
         ST_PQ_B: begin
            u_ctl.start = 1'b1;
            state_in    = ST_PQ_WAIT;
         end
         ST_PQ_WAIT: begin
            if (u_sts.done) begin
               // Strict compares keep the first pair in scan order on ties.
               if (!have_ff || u_dist > fd_ff) begin
                  fd_in = u_dist;
                  f1_in = i_ff[IW-1:0];
                  f2_in = j_ff[IW-1:0];
               end
               if (!have_ff || u_dist < nd_ff) begin
                  nd_in = u_dist;
                  n1_in = i_ff[IW-1:0];
                  n2_in = j_ff[IW-1:0];
               end
               have_in  = 1'b1;
               j_in     = j_ff + 1'b1;
               state_in = ST_PQ_J;
            end
         end
         ST_KEY_SCAN: begin
            cm_raddr = j_ff[IW-1:0];
            if (j_ff == NSLOTS) begin
               i_in     = '0;
               state_in = ST_SO_I;
            end else if (!used_ff[j_ff[IW-1:0]]) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = ST_KEY_A;
            end
         end
         ST_KEY_A: begin
            // Key is the squared distance from the origin.
            u_ctl.start = 1'b1;
            u_a         = cm_rdata_ff;
            u_b         = '0;
            state_in    = ST_KEY_WAIT;
         end
         ST_KEY_WAIT: begin
            if (u_sts.done) begin
               sm_we    = 1'b1;
               sm_waddr = n_ff[IW-1:0];
               sm_wdata = {j_ff[IW-1:0], u_dist};
               n_in     = n_ff + 1'b1;
               j_in     = j_ff + 1'b1;
               state_in = ST_KEY_SCAN;
            end
         end
         ST_SO_I: begin
            if ({1'b0, i_ff} + 1'b1 >= {1'b0, n_ff}) begin
               i_in     = '0;
               state_in = (n_ff == '0) ? ST_RESP : ST_RO_RD;
            end else begin
               state_in = ST_SO_CUR;
            end
         end
         ST_SO_CUR: begin
            cur_in   = sm_rdata_ff;
            j_in     = i_ff + 1'b1;
            state_in = ST_SO_J;
         end
         ST_SO_J: begin
            sm_raddr = j_ff[IW-1:0];
            if (j_ff == n_ff) begin
               // The held entry settles at position i.
               sm_we    = 1'b1;
               i_in     = i_ff + 1'b1;
               state_in = ST_SO_I;
            end else begin
               state_in = ST_SO_CMP;
            end
         end
         ST_SO_CMP: begin
            if (cur_ff[DW-1:0] > sm_rdata_ff[DW-1:0]) begin
               sm_we    = 1'b1;
               sm_waddr = j_ff[IW-1:0];
               cur_in   = sm_rdata_ff;
            end
            j_in     = j_ff + 1'b1;
            state_in = ST_SO_J;
         end
         ST_RO_RD: begin
            state_in = ST_RO_IDX;
         end
         ST_RO_IDX: begin
            cm_raddr = sm_rdata_ff[SW-1:DW];
            state_in = ST_RO_OUT;
         end
         ST_RO_OUT: begin
            opt_in       = cm_rdata_ff;
            last_in      = (i_ff + 1'b1 == n_ff);
            rsp_valid_in = 1'b1;
            state_in     = ST_RO_WAIT;
         end
         ST_RO_WAIT: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               i_in         = i_ff + 1'b1;
               state_in     = last_ff ? ST_IDLE : ST_RO_RD;
            end
         end
         ST_RESP: begin
            last_in      = 1'b1;
            rsp_valid_in = 1'b1;
            state_in     = ST_WAIT;
         end
         ST_WAIT: begin
            if (rsp_ch.ready) begin
               rsp_valid_in = 1'b0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cm_we) begin
         coord_mem_ff[cm_waddr] <= cm_wdata;
      end
      cm_rdata_ff <= coord_mem_ff[cm_raddr];
      if (sm_we) begin
         sort_mem_ff[sm_waddr] <= sm_wdata;
      end
      sm_rdata_ff <= sort_mem_ff[sm_raddr];
   end

   always_ff @(posedge clock) begin
      pt_ff   <= pt_in;
      a_ff    <= a_in;
      ptr_ff  <= ptr_in;
      i_ff    <= i_in;
      j_ff    <= j_in;
      n_ff    <= n_in;
      n1_ff   <= n1_in;
      n2_ff   <= n2_in;
      f1_ff   <= f1_in;
      f2_ff   <= f2_in;
      nd_ff   <= nd_in;
      fd_ff   <= fd_in;
      cur_ff  <= cur_in;
      opt_ff  <= opt_in;
      top_ff  <= top_in;
      if (reset) begin
         state_ff     <= ST_IDLE;
         used_ff      <= '0;
         count_ff     <= '0;
         top_none_ff  <= 1'b1;
         have_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         last_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         count_ff     <= count_in;
         top_none_ff  <= top_none_in;
         have_ff      <= have_in;
         rsp_valid_ff <= rsp_valid_in;
         last_ff      <= last_in;
      end
   end

   // Response fields; stored coordinates sign-extend before truncation.
   logic signed [WIDE-1:0] ox, oy, oz;
   logic [OW-1:0]          nd_wide, fd_wide;

   assign ox      = WIDE'($signed(opt_ff[3*CB-1:2*CB]));
   assign oy      = WIDE'($signed(opt_ff[2*CB-1:CB]));
   assign oz      = WIDE'($signed(opt_ff[CB-1:0]));
   assign nd_wide = OW'(nd_ff);
   assign fd_wide = OW'(fd_ff);

   assign req_ch.ready        = (state_ff == ST_IDLE);
   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.stored_count = pse_pkg::CNT_OUT_W'(count_ff);
   assign rsp_ch.pair_valid   = have_ff;
   assign rsp_ch.near_first   = pse_pkg::IDX_OUT_W'(n1_ff);
   assign rsp_ch.near_second  = pse_pkg::IDX_OUT_W'(n2_ff);
   assign rsp_ch.near_dist_sq = nd_wide[pse_pkg::DIST_OUT_W-1:0];
   assign rsp_ch.far_first    = pse_pkg::IDX_OUT_W'(f1_ff);
   assign rsp_ch.far_second   = pse_pkg::IDX_OUT_W'(f2_ff);
   assign rsp_ch.far_dist_sq  = fd_wide[pse_pkg::DIST_OUT_W-1:0];
   assign rsp_ch.out_x        = ox[pse_pkg::FIELD_W-1:0];
   assign rsp_ch.out_y        = oy[pse_pkg::FIELD_W-1:0];
   assign rsp_ch.out_z        = oz[pse_pkg::FIELD_W-1:0];
   assign rsp_ch.last         = last_ff;
endmodule

// ===== rtl/pse_sqdist.sv =====
// Shared squared distance unit: one multiplier used once per axis.
module pse_sqdist #(
   parameter int COORD_BITS = 16
) (
   input  logic                               clock,
   input  logic                               reset,
   input  pse_pkg::sqd_ctl_type               ctl,
   input  logic [3*COORD_BITS-1:0]            a,
   input  logic [3*COORD_BITS-1:0]            b,
   output pse_pkg::sqd_sts_type               sts,
   output logic [2*(COORD_BITS+1)+1:0]        sum_sq
);
   localparam int CB  = COORD_BITS;
   localparam int DFW = CB + 1;
   localparam int PRW = 2 * DFW;
   localparam int DW  = PRW + 2;

   logic signed [DFW-1:0] dx_ff, dy_ff, dz_ff, dx_in, dy_in, dz_in;
   logic [PRW-1:0]        prod_ff, prod_in;
   logic [DW-1:0]         acc_ff, acc_in;
   logic [1:0]            step_ff, step_in;
   logic                  busy_ff, busy_in, done_ff, done_in;
   logic signed [DFW-1:0] opnd;
   logic signed [PRW-1:0] sq;

   always_comb begin
      unique case (step_ff)
         2'd0:    opnd = dx_ff;
         2'd1:    opnd = dy_ff;
         default: opnd = dz_ff;
      endcase
      sq = opnd * opnd;
   end

   always_comb begin
      dx_in   = dx_ff;
      dy_in   = dy_ff;
      dz_in   = dz_ff;
      prod_in = prod_ff;
      acc_in  = acc_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (ctl.start) begin
         dx_in   = DFW'($signed(a[3*CB-1:2*CB])) - DFW'($signed(b[3*CB-1:2*CB]));
         dy_in   = DFW'($signed(a[2*CB-1:CB])) - DFW'($signed(b[2*CB-1:CB]));
         dz_in   = DFW'($signed(a[CB-1:0])) - DFW'($signed(b[CB-1:0]));
         acc_in  = '0;
         step_in = 2'd0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (step_ff != 2'd0) begin
            acc_in = acc_ff + DW'(prod_ff);
         end
         if (step_ff == 2'd3) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            prod_in = PRW'(sq);
            step_in = step_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      dz_ff   <= dz_in;
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
      step_ff <= step_in;
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   assign sts.done = done_ff;
   assign sum_sq   = acc_ff;
endmodule

// ===== rtl/pse_checker.sv =====
// Port-level checks of the point store, attached to the top level by bind.
module pse_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_pair_valid,
   input logic rsp_last
);
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped before transfer");

   a_busy_on_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("request taken while a response is pending");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("second request taken right after a transfer");

   a_pair_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_pair_valid |-> rsp_last)
      else $error("pair result not a single final response");
endmodule

bind point_store_pair_extremes_top pse_checker u_pse_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_pair_valid (rsp_ch.pair_valid),
   .rsp_last       (rsp_ch.last)
);
